// ===== src/pbld_pkg.sv =====
// Package for the proximity blink LED driver: field widths, command and
// register codes, register reset values and channel counts.
// No dependencies.
`default_nettype none

package pbld_pkg;

  // Channel counts: NUM_CHANNELS channels are built, FIELD_CHANNELS appear in the items
  localparam int NUM_CHANNELS   = 3;
  localparam int FIELD_CHANNELS = 3;

  // Ticks between two measurement requests (1..255)
  localparam int SENSOR_TICKS = 5;

  // Field and register widths
  localparam int CMD_W    = 2;
  localparam int DIST_W   = 10;
  localparam int PERIOD_W = 8;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 8;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [PERIOD_W-1:0] SENSOR_TICKS_V = PERIOD_W'(SENSOR_TICKS);
  localparam logic [SEC_W-1:0]    SEC_LAST       = SEC_W'(59);
  localparam logic [MIN_W-1:0]    MIN_MAX        = '1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POWER = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_FAR     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_MID     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_NEAR    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_FAR     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_MID     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_NEAR    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_CLOSEST = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_SEC = 3'd7;

  // Register reset values
  localparam logic [DIST_W-1:0]   RST_LIMIT_FAR     = 10'd100;
  localparam logic [DIST_W-1:0]   RST_LIMIT_MID     = 10'd50;
  localparam logic [DIST_W-1:0]   RST_LIMIT_NEAR    = 10'd20;
  localparam logic [PERIOD_W-1:0] RST_BLINK_FAR     = 8'd8;
  localparam logic [PERIOD_W-1:0] RST_BLINK_MID     = 8'd4;
  localparam logic [PERIOD_W-1:0] RST_BLINK_NEAR    = 8'd2;
  localparam logic [PERIOD_W-1:0] RST_BLINK_CLOSEST = 8'd1;
  localparam logic [PERIOD_W-1:0] RST_TICKS_PER_SEC = 8'd10;

endpackage

`default_nettype wire

// ===== src/pbld_in_if.sv =====
// Input channel of the proximity blink LED driver: valid/ready plus one
// command and three distances. Depends on pbld_pkg.
`default_nettype none

interface pbld_in_if;
  logic                        valid;
  logic                        ready;
  logic [pbld_pkg::CMD_W-1:0]  command;
  logic [pbld_pkg::DIST_W-1:0] distance_0;
  logic [pbld_pkg::DIST_W-1:0] distance_1;
  logic [pbld_pkg::DIST_W-1:0] distance_2;

  modport source (output valid, command, distance_0, distance_1, distance_2,
                  input ready);
  modport sink   (input valid, command, distance_0, distance_1, distance_2,
                  output ready);
endinterface

`default_nettype wire

// ===== src/pbld_out_if.sv =====
// Result channel of the proximity blink LED driver: valid/ready plus lamp,
// activity, clock and status fields. Depends on pbld_pkg.
`default_nettype none

interface pbld_out_if;
  logic                       valid;
  logic                       ready;
  logic                       lamp_0;
  logic                       lamp_1;
  logic                       lamp_2;
  logic                       active_0;
  logic                       active_1;
  logic                       active_2;
  logic [pbld_pkg::SEC_W-1:0] seconds;
  logic [pbld_pkg::MIN_W-1:0] minutes;
  logic                       measure_request;
  logic                       system_on;

  modport source (output valid, lamp_0, lamp_1, lamp_2, active_0, active_1, active_2,
                  seconds, minutes, measure_request, system_on,
                  input ready);
  modport sink   (input valid, lamp_0, lamp_1, lamp_2, active_0, active_1, active_2,
                  seconds, minutes, measure_request, system_on,
                  output ready);
endinterface

`default_nettype wire

// ===== src/proximity_blink_led_driver_unit.sv =====
// Proximity blink LED driver top level: APB register file, input register,
// state update and result register. Depends on pbld_pkg, pbld_in_if, pbld_out_if.
//
// The block takes one request per clock unless the sink stalls, and returns
// exactly one result per request, via the input register, then the result
// register. The state update for a request (blink classing, blink counters,
// measurement pacing, seconds/minutes clock, power toggle) is one pass of
// compare-and-increment logic between those two registers, so back-to-back
// requests run at full rate; ready drops only when the result register is
// held by a stalled sink and the input register is full. Registers are
// written over APB at byte address 4*index and should be written only while
// no request is in flight.
`default_nettype none

module proximity_blink_led_driver_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  pbld_in_if.sink                              items,
  pbld_out_if.source                           results,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pbld_pkg::APB_AW-1:0]     paddr,
  input  wire logic [pbld_pkg::APB_DW-1:0]     pwdata,
  output logic      [pbld_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready
);

  localparam int NCH = pbld_pkg::NUM_CHANNELS;
  localparam int FCH = pbld_pkg::FIELD_CHANNELS;

  // Configuration registers
  logic [pbld_pkg::DIST_W-1:0]    limit_far, limit_mid, limit_near;
  logic [pbld_pkg::PERIOD_W-1:0]  blink_far, blink_mid, blink_near, blink_closest;
  logic [pbld_pkg::PERIOD_W-1:0]  ticks_per_second;
  logic                           cfg_write;
  logic [pbld_pkg::REG_IDX_W-1:0] cfg_idx;

  // Input register
  logic                          s1_valid;
  logic [pbld_pkg::CMD_W-1:0]    s1_command;
  logic [pbld_pkg::DIST_W-1:0]   s1_dist [FCH];
  logic                          s1_fire;
  logic                          res_free;
  logic                          in_fire;

  // Block state
  logic                          powered, powered_next;
  logic [pbld_pkg::PERIOD_W-1:0] second_tick_count, second_tick_count_next;
  logic [pbld_pkg::PERIOD_W-1:0] sensor_tick_count, sensor_tick_count_next;
  logic [pbld_pkg::PERIOD_W-1:0] blink_count [NCH];
  logic [pbld_pkg::PERIOD_W-1:0] blink_count_next [NCH];
  logic [pbld_pkg::PERIOD_W-1:0] blink_period [NCH];
  logic [pbld_pkg::PERIOD_W-1:0] blink_period_next [NCH];
  logic [NCH-1:0]                channel_active, channel_active_next;
  logic [NCH-1:0]                lamp_lit, lamp_lit_next;
  logic [pbld_pkg::SEC_W-1:0]    elapsed_seconds, elapsed_seconds_next;
  logic [pbld_pkg::MIN_W-1:0]    elapsed_minutes, elapsed_minutes_next;
  logic                          request_next;

  // Result register
  logic                          res_valid;
  logic [FCH-1:0]                res_lamp, res_active;
  logic [FCH-1:0]                lamp_field, active_field;
  logic [pbld_pkg::SEC_W-1:0]    res_seconds;
  logic [pbld_pkg::MIN_W-1:0]    res_minutes;
  logic                          res_measure;
  logic                          res_system_on;

  // APB: always ready, write on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[pbld_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_far        <= pbld_pkg::RST_LIMIT_FAR;
      limit_mid        <= pbld_pkg::RST_LIMIT_MID;
      limit_near       <= pbld_pkg::RST_LIMIT_NEAR;
      blink_far        <= pbld_pkg::RST_BLINK_FAR;
      blink_mid        <= pbld_pkg::RST_BLINK_MID;
      blink_near       <= pbld_pkg::RST_BLINK_NEAR;
      blink_closest    <= pbld_pkg::RST_BLINK_CLOSEST;
      ticks_per_second <= pbld_pkg::RST_TICKS_PER_SEC;
    end else if (cfg_write) begin
      case (cfg_idx)
        pbld_pkg::REG_LIMIT_FAR:     limit_far        <= pwdata[pbld_pkg::DIST_W-1:0];
        pbld_pkg::REG_LIMIT_MID:     limit_mid        <= pwdata[pbld_pkg::DIST_W-1:0];
        pbld_pkg::REG_LIMIT_NEAR:    limit_near       <= pwdata[pbld_pkg::DIST_W-1:0];
        pbld_pkg::REG_BLINK_FAR:     blink_far        <= pwdata[pbld_pkg::PERIOD_W-1:0];
        pbld_pkg::REG_BLINK_MID:     blink_mid        <= pwdata[pbld_pkg::PERIOD_W-1:0];
        pbld_pkg::REG_BLINK_NEAR:    blink_near       <= pwdata[pbld_pkg::PERIOD_W-1:0];
        pbld_pkg::REG_BLINK_CLOSEST: blink_closest    <= pwdata[pbld_pkg::PERIOD_W-1:0];
        pbld_pkg::REG_TICKS_PER_SEC: ticks_per_second <= pwdata[pbld_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_idx)
      pbld_pkg::REG_LIMIT_FAR:     prdata = pbld_pkg::APB_DW'(limit_far);
      pbld_pkg::REG_LIMIT_MID:     prdata = pbld_pkg::APB_DW'(limit_mid);
      pbld_pkg::REG_LIMIT_NEAR:    prdata = pbld_pkg::APB_DW'(limit_near);
      pbld_pkg::REG_BLINK_FAR:     prdata = pbld_pkg::APB_DW'(blink_far);
      pbld_pkg::REG_BLINK_MID:     prdata = pbld_pkg::APB_DW'(blink_mid);
      pbld_pkg::REG_BLINK_NEAR:    prdata = pbld_pkg::APB_DW'(blink_near);
      pbld_pkg::REG_BLINK_CLOSEST: prdata = pbld_pkg::APB_DW'(blink_closest);
      pbld_pkg::REG_TICKS_PER_SEC: prdata = pbld_pkg::APB_DW'(ticks_per_second);
      default:                     prdata = '0;
    endcase
  end

  // Pipeline flow: result register frees when empty or taken
  assign res_free    = !res_valid || results.ready;
  assign s1_fire     = s1_valid && res_free;
  assign items.ready = !s1_valid || res_free;
  assign in_fire     = items.valid && items.ready;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
    if (in_fire) begin
      s1_command <= items.command;
      s1_dist[0] <= items.distance_0;
      s1_dist[1] <= items.distance_1;
      s1_dist[2] <= items.distance_2;
    end
  end

  // Next state for the registered request
  always_comb begin
    logic [pbld_pkg::DIST_W-1:0] d;
    logic [pbld_pkg::PERIOD_W-1:0] bc;
    powered_next           = powered;
    second_tick_count_next = second_tick_count;
    sensor_tick_count_next = sensor_tick_count;
    blink_count_next       = blink_count;
    blink_period_next      = blink_period;
    channel_active_next    = channel_active;
    lamp_lit_next          = lamp_lit;
    elapsed_seconds_next   = elapsed_seconds;
    elapsed_minutes_next   = elapsed_minutes;
    request_next           = 1'b0;
    d  = '0;
    bc = '0;
    case (s1_command)
      pbld_pkg::CMD_TICK: begin
        if (powered) begin
          // Elapsed clock
          second_tick_count_next = second_tick_count + pbld_pkg::PERIOD_W'(1);
          if (second_tick_count_next == ticks_per_second) begin
            second_tick_count_next = '0;
            if (elapsed_seconds == pbld_pkg::SEC_LAST) begin
              elapsed_seconds_next = '0;
              if (elapsed_minutes != pbld_pkg::MIN_MAX) begin
                elapsed_minutes_next = elapsed_minutes + pbld_pkg::MIN_W'(1);
              end
            end else begin
              elapsed_seconds_next = elapsed_seconds + pbld_pkg::SEC_W'(1);
            end
          end
          // Measurement pacing
          sensor_tick_count_next = sensor_tick_count + pbld_pkg::PERIOD_W'(1);
          if (sensor_tick_count_next == pbld_pkg::SENSOR_TICKS_V) begin
            sensor_tick_count_next = '0;
            request_next           = 1'b1;
          end
          // Blink counters; toggle active lamps on a period match
          for (int ch = 0; ch < NCH; ch++) begin
            bc = blink_count[ch] + pbld_pkg::PERIOD_W'(1);
            if (blink_period[ch] != '0 && bc == blink_period[ch]) begin
              bc = '0;
              if (channel_active[ch]) begin
                lamp_lit_next[ch] = !lamp_lit[ch];
              end
            end
            blink_count_next[ch] = bc;
          end
        end
      end
      pbld_pkg::CMD_DIST: begin
        if (powered) begin
          // Class each channel and restart its counter
          for (int ch = 0; ch < NCH; ch++) begin
            d = (ch < FCH) ? s1_dist[ch] : '0;
            if (d == '0) begin
              channel_active_next[ch] = 1'b0;
              lamp_lit_next[ch]       = 1'b0;
              blink_period_next[ch]   = '0;
            end else begin
              channel_active_next[ch] = 1'b1;
              if (d >= limit_far) begin
                blink_period_next[ch] = blink_far;
              end else if (d >= limit_mid) begin
                blink_period_next[ch] = blink_mid;
              end else if (d >= limit_near) begin
                blink_period_next[ch] = blink_near;
              end else begin
                blink_period_next[ch] = blink_closest;
              end
            end
            blink_count_next[ch] = '0;
          end
        end
      end
      pbld_pkg::CMD_POWER: begin
        if (!powered) begin
          powered_next = 1'b1;
          request_next = 1'b1;
        end else begin
          // Power off: drop all state
          powered_next           = 1'b0;
          second_tick_count_next = '0;
          sensor_tick_count_next = '0;
          for (int ch = 0; ch < NCH; ch++) begin
            blink_count_next[ch]  = '0;
            blink_period_next[ch] = '0;
          end
          channel_active_next  = '0;
          lamp_lit_next        = '0;
          elapsed_seconds_next = '0;
          elapsed_minutes_next = '0;
        end
      end
      default: ;
    endcase
  end

  // Map channels onto the fixed result fields
  always_comb begin
    lamp_field   = '0;
    active_field = '0;
    for (int ch = 0; ch < FCH; ch++) begin
      if (ch < NCH) begin
        lamp_field[ch]   = lamp_lit_next[ch];
        active_field[ch] = channel_active_next[ch];
      end
    end
  end

  // Advance state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      powered           <= 1'b0;
      second_tick_count <= '0;
      sensor_tick_count <= '0;
      for (int ch = 0; ch < NCH; ch++) begin
        blink_count[ch]  <= '0;
        blink_period[ch] <= '0;
      end
      channel_active  <= '0;
      lamp_lit        <= '0;
      elapsed_seconds <= '0;
      elapsed_minutes <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (s1_fire) begin
        powered           <= powered_next;
        second_tick_count <= second_tick_count_next;
        sensor_tick_count <= sensor_tick_count_next;
        blink_count       <= blink_count_next;
        blink_period      <= blink_period_next;
        channel_active    <= channel_active_next;
        lamp_lit          <= lamp_lit_next;
        elapsed_seconds   <= elapsed_seconds_next;
        elapsed_minutes   <= elapsed_minutes_next;
      end
      if (res_free) begin
        res_valid <= s1_valid;
      end
    end
    if (s1_fire) begin
      res_lamp      <= lamp_field;
      res_active    <= active_field;
      res_seconds   <= elapsed_seconds_next;
      res_minutes   <= elapsed_minutes_next;
      res_measure   <= request_next;
      res_system_on <= powered_next;
    end
  end

  // Drive the result channel
  assign results.valid           = res_valid;
  assign results.lamp_0          = res_lamp[0];
  assign results.lamp_1          = res_lamp[1];
  assign results.lamp_2          = res_lamp[2];
  assign results.active_0        = res_active[0];
  assign results.active_1        = res_active[1];
  assign results.active_2        = res_active[2];
  assign results.seconds         = res_seconds;
  assign results.minutes         = res_minutes;
  assign results.measure_request = res_measure;
  assign results.system_on       = res_system_on;

  // Powered off means all channel and clock state is cleared
  a_off_cleared: assert property (@(posedge clk) disable iff (rst)
    !powered |-> (channel_active == '0 && lamp_lit == '0 &&
                  elapsed_seconds == '0 && elapsed_minutes == '0))
    else $error("state not cleared while powered off");

  // A lamp is lit only on an active channel
  a_lamp_active: assert property (@(posedge clk) disable iff (rst)
    (lamp_lit & ~channel_active) == '0)
    else $error("lamp lit on inactive channel");

  // Seconds stay below one minute
  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    elapsed_seconds <= pbld_pkg::SEC_LAST)
    else $error("seconds out of range");

  // A measurement request only comes with the system on
  a_request_on: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_measure) |-> res_system_on)
    else $error("measure request while off");

  // A full input register that cannot move blocks new requests
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> !items.ready)
    else $error("input register overwritten");

endmodule

`default_nettype wire

// ===== dv/tb_proximity_blink_led_driver_unit.sv =====
// Self-checking testbench for the proximity blink LED driver: predicts every
// result from its own copy of the lamp, blink and clock state and checks it.
// Depends on pbld_pkg, pbld_in_if, pbld_out_if and proximity_blink_led_driver_unit.

module tb_proximity_blink_led_driver_unit;

  // Command code with no meaning to the block
  localparam logic [pbld_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CLOCK_TICKS = 130;

  typedef struct packed {
    logic [pbld_pkg::CMD_W-1:0]                                 command;
    logic [pbld_pkg::FIELD_CHANNELS-1:0][pbld_pkg::DIST_W-1:0] distance;
  } lamp_request_t;

  typedef struct packed {
    logic [pbld_pkg::FIELD_CHANNELS-1:0] lamp;
    logic [pbld_pkg::FIELD_CHANNELS-1:0] active;
    logic [pbld_pkg::SEC_W-1:0]          seconds;
    logic [pbld_pkg::MIN_W-1:0]          minutes;
    logic                                measure;
    logic                                powered;
  } lamp_status_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_BURSTY} stall_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Testbench-side drive of every block input, known from time zero
  logic          src_valid  = 1'b0;
  lamp_request_t src_req    = '0;
  logic          sink_ready = 1'b0;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [pbld_pkg::APB_AW-1:0] paddr   = '0;
  logic [pbld_pkg::APB_DW-1:0] pwdata  = '0;
  logic [pbld_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  pbld_in_if  req_if ();
  pbld_out_if res_if ();

  assign req_if.valid      = src_valid;
  assign req_if.command    = src_req.command;
  assign req_if.distance_0 = src_req.distance[0];
  assign req_if.distance_1 = src_req.distance[1];
  assign req_if.distance_2 = src_req.distance[2];
  assign res_if.ready      = sink_ready;

  proximity_blink_led_driver_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (req_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Register copies, written only by the configuration sequence
  logic [pbld_pkg::DIST_W-1:0]   lim_far     = pbld_pkg::RST_LIMIT_FAR;
  logic [pbld_pkg::DIST_W-1:0]   lim_mid     = pbld_pkg::RST_LIMIT_MID;
  logic [pbld_pkg::DIST_W-1:0]   lim_near    = pbld_pkg::RST_LIMIT_NEAR;
  logic [pbld_pkg::PERIOD_W-1:0] per_far     = pbld_pkg::RST_BLINK_FAR;
  logic [pbld_pkg::PERIOD_W-1:0] per_mid     = pbld_pkg::RST_BLINK_MID;
  logic [pbld_pkg::PERIOD_W-1:0] per_near    = pbld_pkg::RST_BLINK_NEAR;
  logic [pbld_pkg::PERIOD_W-1:0] per_closest = pbld_pkg::RST_BLINK_CLOSEST;
  logic [pbld_pkg::PERIOD_W-1:0] sec_len     = pbld_pkg::RST_TICKS_PER_SEC;

  // Predicted block state, updated by the driver on each accepted request
  logic                          m_powered;
  logic [pbld_pkg::PERIOD_W-1:0] m_sec_ticks;
  logic [pbld_pkg::PERIOD_W-1:0] m_meas_ticks;
  logic [pbld_pkg::PERIOD_W-1:0] m_blink_cnt [pbld_pkg::NUM_CHANNELS];
  logic [pbld_pkg::PERIOD_W-1:0] m_blink_per [pbld_pkg::NUM_CHANNELS];
  logic                          m_active    [pbld_pkg::NUM_CHANNELS];
  logic                          m_lamp      [pbld_pkg::NUM_CHANNELS];
  logic [pbld_pkg::SEC_W-1:0]    m_seconds;
  logic [pbld_pkg::MIN_W-1:0]    m_minutes;

  lamp_request_t pending_requests [$];
  lamp_status_t  expected_status  [$];

  int  cycle_count = 0;
  int  err_count   = 0;
  bit  gen_powered = 1'b0;
  int  gap_left    = 0;
  int  burst_left  = 0;
  bit  holding;
  lamp_status_t accepted_status;
  lamp_status_t want;
  stall_mode_e  stall_mode = STALL_NONE;
  int  stall_left  = 0;
  int  mode_left   = 0;

  function automatic void clear_model();
    m_powered    = 1'b0;
    m_sec_ticks  = '0;
    m_meas_ticks = '0;
    m_seconds    = '0;
    m_minutes    = '0;
    for (int ch = 0; ch < pbld_pkg::NUM_CHANNELS; ch++) begin
      m_blink_cnt[ch] = '0;
      m_blink_per[ch] = '0;
      m_active[ch]    = 1'b0;
      m_lamp[ch]      = 1'b0;
    end
  endfunction

  // Apply one request to the predicted state and return the status it shows
  task automatic predict_status(input lamp_request_t req, output lamp_status_t st);
    logic                        want_meas;
    logic [pbld_pkg::DIST_W-1:0] d;
    want_meas = 1'b0;
    case (req.command)
      pbld_pkg::CMD_TICK: begin
        if (m_powered) begin
          m_sec_ticks = m_sec_ticks + 8'd1;
          if (m_sec_ticks == sec_len) begin
            m_sec_ticks = '0;
            if (m_seconds == pbld_pkg::SEC_LAST) begin
              m_seconds = '0;
              if (m_minutes != pbld_pkg::MIN_MAX) m_minutes = m_minutes + 8'd1;
            end else begin
              m_seconds = m_seconds + 6'd1;
            end
          end
          m_meas_ticks = m_meas_ticks + 8'd1;
          if (m_meas_ticks == pbld_pkg::SENSOR_TICKS_V) begin
            m_meas_ticks = '0;
            want_meas    = 1'b1;
          end
          for (int ch = 0; ch < pbld_pkg::NUM_CHANNELS; ch++) begin
            m_blink_cnt[ch] = m_blink_cnt[ch] + 8'd1;
            if (m_blink_per[ch] != '0 && m_blink_cnt[ch] == m_blink_per[ch]) begin
              m_blink_cnt[ch] = '0;
              if (m_active[ch]) m_lamp[ch] = ~m_lamp[ch];
            end
          end
        end
      end
      pbld_pkg::CMD_DIST: begin
        if (m_powered) begin
          for (int ch = 0; ch < pbld_pkg::NUM_CHANNELS; ch++) begin
            d = req.distance[ch];
            if (d == '0) begin
              m_active[ch]    = 1'b0;
              m_lamp[ch]      = 1'b0;
              m_blink_per[ch] = '0;
            end else begin
              m_active[ch] = 1'b1;
              if (d >= lim_far)       m_blink_per[ch] = per_far;
              else if (d >= lim_mid)  m_blink_per[ch] = per_mid;
              else if (d >= lim_near) m_blink_per[ch] = per_near;
              else                    m_blink_per[ch] = per_closest;
            end
            m_blink_cnt[ch] = '0;
          end
        end
      end
      pbld_pkg::CMD_POWER: begin
        if (!m_powered) begin
          m_powered = 1'b1;
          want_meas = 1'b1;
        end else begin
          clear_model();
        end
      end
      default: ;
    endcase
    for (int ch = 0; ch < pbld_pkg::NUM_CHANNELS; ch++) begin
      st.lamp[ch]   = m_lamp[ch];
      st.active[ch] = m_active[ch];
    end
    st.seconds = m_seconds;
    st.minutes = m_minutes;
    st.measure = want_meas;
    st.powered = m_powered;
  endtask

  task automatic report(input string msg);
    if (err_count < 50) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v) report($sformatf("%s got %0h want %0h", name, got, exp_v));
  endtask

  // Driver: hold a request until accepted, then predict it; bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      clear_model();
      gap_left   = 0;
      burst_left = 0;
    end else begin
      holding = src_valid;
      if (src_valid && req_if.ready) begin
        predict_status(pending_requests.pop_front(), accepted_status);
        expected_status.push_back(accepted_status);
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          src_valid <= 1'b1;
          src_req   <= pending_requests[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(32, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left--;
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between random stall patterns
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(2));
        mode_left  = $urandom_range(96, 16);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_NONE:   sink_ready <= 1'b1;
          STALL_SPARSE: sink_ready <= ($urandom_range(3) != 0);
          default: begin
            if ($urandom_range(5) == 0) begin
              stall_left = $urandom_range(7);
              sink_ready <= 1'b0;
            end else begin
              sink_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_if.valid && sink_ready) begin
      if (expected_status.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = expected_status.pop_front();
        check_field("lamp_0", res_if.lamp_0, want.lamp[0]);
        check_field("lamp_1", res_if.lamp_1, want.lamp[1]);
        check_field("lamp_2", res_if.lamp_2, want.lamp[2]);
        check_field("active_0", res_if.active_0, want.active[0]);
        check_field("active_1", res_if.active_1, want.active[1]);
        check_field("active_2", res_if.active_2, want.active[2]);
        check_field("seconds", res_if.seconds, want.seconds);
        check_field("minutes", res_if.minutes, want.minutes);
        check_field("measure_request", res_if.measure_request, want.measure);
        check_field("system_on", res_if.system_on, want.powered);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_item(input logic [pbld_pkg::CMD_W-1:0] cmd, input int d0, input int d1,
                           input int d2);
    lamp_request_t it;
    it.command     = cmd;
    it.distance[0] = pbld_pkg::DIST_W'(d0);
    it.distance[1] = pbld_pkg::DIST_W'(d1);
    it.distance[2] = pbld_pkg::DIST_W'(d2);
    pending_requests.push_back(it);
    if (cmd == pbld_pkg::CMD_POWER) gen_powered = ~gen_powered;
  endtask

  // Favor zero, the limit edges and the field extremes
  function automatic int pick_distance();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 15) begin
      v = 0;
    end else if (r < 40) begin
      case ($urandom_range(2))
        0:       v = int'(lim_far);
        1:       v = int'(lim_mid);
        default: v = int'(lim_near);
      endcase
      v = v + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
    end else if (r < 50) begin
      v = ($urandom_range(1) != 0) ? 1023 : 1;
    end else begin
      v = $urandom_range(1023, 1);
    end
    return v;
  endfunction

  // Queue random requests until n of them are ones the block acts on
  task automatic run_random(input int n);
    int done;
    int r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (gen_powered) begin
        if (r < 80) begin
          push_item(pbld_pkg::CMD_TICK, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023));
          done++;
        end else if (r < 92) begin
          push_item(pbld_pkg::CMD_DIST, pick_distance(), pick_distance(), pick_distance());
          done++;
        end else if (r < 95) begin
          push_item(pbld_pkg::CMD_POWER, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023));
          done++;
        end else begin
          push_item(CMD_UNUSED, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023));
        end
      end else if (r < 60) begin
        push_item(pbld_pkg::CMD_POWER, $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023));
        done++;
      end else begin
        push_item((r < 75) ? pbld_pkg::CMD_TICK : (r < 90) ? pbld_pkg::CMD_DIST : CMD_UNUSED,
                  pick_distance(), pick_distance(), pick_distance());
      end
    end
  endtask

  // Hold off until every queued request has been answered
  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_status.size() != 0 || src_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pbld_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pbld_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pbld_pkg::REG_LIMIT_FAR:     lim_far     = value[pbld_pkg::DIST_W-1:0];
      pbld_pkg::REG_LIMIT_MID:     lim_mid     = value[pbld_pkg::DIST_W-1:0];
      pbld_pkg::REG_LIMIT_NEAR:    lim_near    = value[pbld_pkg::DIST_W-1:0];
      pbld_pkg::REG_BLINK_FAR:     per_far     = value[pbld_pkg::PERIOD_W-1:0];
      pbld_pkg::REG_BLINK_MID:     per_mid     = value[pbld_pkg::PERIOD_W-1:0];
      pbld_pkg::REG_BLINK_NEAR:    per_near    = value[pbld_pkg::PERIOD_W-1:0];
      pbld_pkg::REG_BLINK_CLOSEST: per_closest = value[pbld_pkg::PERIOD_W-1:0];
      default:                     sec_len     = value[pbld_pkg::PERIOD_W-1:0];
    endcase
  endtask

  task automatic write_all(input int lf, input int lm, input int ln, input int bf,
                           input int bm, input int bn, input int bc, input int tps);
    write_reg(pbld_pkg::REG_LIMIT_FAR, lf);
    write_reg(pbld_pkg::REG_LIMIT_MID, lm);
    write_reg(pbld_pkg::REG_LIMIT_NEAR, ln);
    write_reg(pbld_pkg::REG_BLINK_FAR, bf);
    write_reg(pbld_pkg::REG_BLINK_MID, bm);
    write_reg(pbld_pkg::REG_BLINK_NEAR, bn);
    write_reg(pbld_pkg::REG_BLINK_CLOSEST, bc);
    write_reg(pbld_pkg::REG_TICKS_PER_SEC, tps);
  endtask

  task automatic write_random_config();
    write_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
              $urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1),
              $urandom_range(6, 1), $urandom_range(20, 1));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: requests while off, then every class edge at reset limits
    push_item(pbld_pkg::CMD_TICK, 1023, 1023, 1023);
    push_item(pbld_pkg::CMD_DIST, 1023, 1023, 1023);
    push_item(CMD_UNUSED, 0, 0, 0);
    push_item(pbld_pkg::CMD_POWER, 0, 0, 0);
    push_item(pbld_pkg::CMD_DIST, 100, 99, 50);
    repeat (10) push_item(pbld_pkg::CMD_TICK, 0, 0, 0);
    push_item(pbld_pkg::CMD_DIST, 49, 20, 19);
    repeat (3) push_item(pbld_pkg::CMD_TICK, 0, 0, 0);
    // Lit channel going dark clears its lamp; lit channel kept keeps its level
    push_item(pbld_pkg::CMD_DIST, 1, 0, 1023);
    push_item(CMD_UNUSED, 1023, 1023, 1023);
    push_item(pbld_pkg::CMD_DIST, 5, 5, 5);
    push_item(pbld_pkg::CMD_TICK, 1023, 1023, 1023);
    push_item(pbld_pkg::CMD_POWER, 1023, 1023, 1023);
    push_item(pbld_pkg::CMD_TICK, 0, 0, 0);
    wait_drained();

    write_random_config();
    run_random(250);
    wait_drained();

    // Extremes: top and zero limits, zero blink registers, zero second length
    write_all(1023, 1023, 0, 255, 0, 1, 0, 0);
    run_random(150);
    wait_drained();

    // Minute rollover: one second per tick, no power cycling
    write_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
              $urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1),
              $urandom_range(6, 1), 1);
    if (gen_powered) push_item(pbld_pkg::CMD_POWER, 0, 0, 0);
    push_item(pbld_pkg::CMD_POWER, 0, 0, 0);
    for (int i = 0; i < CLOCK_TICKS; i++) begin
      if ($urandom_range(19) == 0)
        push_item(pbld_pkg::CMD_DIST, pick_distance(), pick_distance(), pick_distance());
      else
        push_item(pbld_pkg::CMD_TICK, $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023));
    end
    wait_drained();

    // Extremes: zero limits, fastest far class, longest second
    write_all(0, 0, 0, 1, 255, 255, 255, 255);
    run_random(120);
    wait_drained();

    write_random_config();
    run_random(200);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
